### sv/ldw_pkg.sv
package ldw_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int IN_WIDTH   = 40;

    typedef logic [2:0] field_idx_t;
    typedef logic [2:0] pos_t;

    // Field order is also the order in which fields are written.
    localparam field_idx_t FLD_DAY    = 3'd0;
    localparam field_idx_t FLD_MONTH  = 3'd1;
    localparam field_idx_t FLD_YEAR   = 3'd2;
    localparam field_idx_t FLD_HOUR   = 3'd3;
    localparam field_idx_t FLD_MINUTE = 3'd4;
    localparam field_idx_t FLD_SECOND = 3'd5;

    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic [7:0] CMD_CUR_DAY     = 8'h80;
    localparam logic [7:0] CMD_CUR_MONTH   = 8'h83;
    localparam logic [7:0] CMD_CUR_YEAR    = 8'h86;
    localparam logic [7:0] CMD_CUR_HOUR    = 8'hC0;
    localparam logic [7:0] CMD_CUR_MINUTE  = 8'hC3;
    localparam logic [7:0] CMD_CUR_SECOND  = 8'hC6;
    localparam logic [7:0] ASCII_SLASH     = 8'h2F;
    localparam logic [7:0] ASCII_COLON     = 8'h3A;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] ASCII_NINE      = 8'h39;

    localparam logic [13:0] YEAR_WRAP = 14'd10000;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } snap_t;

    // Captured snapshot; year already reduced below 10000.
    typedef struct packed {
        snap_t      snap;
        logic [5:0] mask;
        logic       full;
    } capt_t;

    // Two-digit fields are indexed day, month, hour, minute, second.
    typedef struct packed {
        logic [4:0][3:0] tens;
        logic [4:0][3:0] units;
        logic [13:0]     year_low;
        logic [9:0]      q10;
        logic [6:0]      q100;
        logic [3:0]      q1000;
        logic [5:0]      mask;
        logic            full;
    } conv_t;

    typedef struct packed {
        logic [5:0] mask;
        pos_t       pos;
    } ser_status_t;

    function automatic pos_t field_len(input field_idx_t f);
        return (f == FLD_YEAR) ? 3'd4 : 3'd2;
    endfunction

    function automatic logic [3:0] digit_base(input field_idx_t f);
        logic [3:0] b;
        case (f)
            FLD_DAY:    b = 4'd0;
            FLD_MONTH:  b = 4'd2;
            FLD_YEAR:   b = 4'd4;
            FLD_HOUR:   b = 4'd8;
            FLD_MINUTE: b = 4'd10;
            FLD_SECOND: b = 4'd12;
            default:    b = 4'd0;
        endcase
        return b;
    endfunction

    // Byte written ahead of a field's digits: a separator, the home command or the
    // line-two command in the full layout, a cursor command in a partial update.
    function automatic logic [7:0] prefix_byte(input logic full, input field_idx_t f);
        logic [7:0] b;
        case (f)
            FLD_DAY:    b = full ? CMD_HOME : CMD_CUR_DAY;
            FLD_MONTH:  b = full ? ASCII_SLASH : CMD_CUR_MONTH;
            FLD_YEAR:   b = full ? ASCII_SLASH : CMD_CUR_YEAR;
            FLD_HOUR:   b = CMD_CUR_HOUR;
            FLD_MINUTE: b = full ? ASCII_COLON : CMD_CUR_MINUTE;
            FLD_SECOND: b = full ? ASCII_COLON : CMD_CUR_SECOND;
            default:    b = CMD_HOME;
        endcase
        return b;
    endfunction

    function automatic logic prefix_is_cmd(input logic full, input field_idx_t f);
        return !full || (f == FLD_DAY) || (f == FLD_HOUR);
    endfunction

    function automatic field_idx_t lowest_field(input logic [5:0] mask);
        field_idx_t idx;
        idx = FLD_DAY;
        for (int i = NUM_FIELDS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = field_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

### sv/ldw_capture.sv
module ldw_capture (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ldw_pkg::IN_WIDTH-1:0]  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ldw_pkg::capt_t                out_capt
);

    ldw_pkg::snap_t in_snap;
    ldw_pkg::capt_t capt_reg;
    ldw_pkg::snap_t prev_reg;
    logic           valid_reg;
    logic           shown_once_reg;
    logic [5:0]     diff;
    logic           take;

    assign in_snap.day    = in_data[4:0];
    assign in_snap.month  = in_data[8:5];
    assign in_snap.year   = in_data[22:9];
    assign in_snap.hour   = in_data[27:23];
    assign in_snap.minute = in_data[33:28];
    assign in_snap.second = in_data[39:34];

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Bit order follows the field index constants.
    assign diff = {in_snap.second != prev_reg.second,
                   in_snap.minute != prev_reg.minute,
                   in_snap.hour   != prev_reg.hour,
                   in_snap.year   != prev_reg.year,
                   in_snap.month  != prev_reg.month,
                   in_snap.day    != prev_reg.day};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            shown_once_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg      <= 1'b1;
                shown_once_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_reg             <= in_snap;
            capt_reg.snap.day    <= in_snap.day;
            capt_reg.snap.month  <= in_snap.month;
            // Only the low four decimal digits of the year are shown.
            capt_reg.snap.year   <= (in_snap.year >= ldw_pkg::YEAR_WRAP)
                                    ? in_snap.year - ldw_pkg::YEAR_WRAP : in_snap.year;
            capt_reg.snap.hour   <= in_snap.hour;
            capt_reg.snap.minute <= in_snap.minute;
            capt_reg.snap.second <= in_snap.second;
            capt_reg.mask        <= shown_once_reg ? diff : 6'b111111;
            capt_reg.full        <= !shown_once_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_capt  = capt_reg;

endmodule

### sv/ldw_bcd.sv
module ldw_bcd (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ldw_pkg::capt_t in_capt,
    output logic           out_valid,
    input  logic           out_ready,
    output ldw_pkg::conv_t out_conv
);

    ldw_pkg::conv_t  conv_reg;
    ldw_pkg::conv_t  conv_next;
    logic            valid_reg;
    logic            take;
    logic [4:0][5:0] vals;
    logic [4:0][13:0] prod_tens;
    logic [29:0]     p10;
    logic [26:0]     p100;
    logic [27:0]     p1000;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign vals[0] = {1'b0, in_capt.snap.day};
    assign vals[1] = {2'b00, in_capt.snap.month};
    assign vals[2] = {1'b0, in_capt.snap.hour};
    assign vals[3] = in_capt.snap.minute;
    assign vals[4] = in_capt.snap.second;

    // Division by 10 as a reciprocal multiply; exact for the six-bit values here.
    always_comb
    begin
        conv_next = '0;
        for (int i = 0; i < 5; i++)
        begin
            prod_tens[i]       = 14'(vals[i]) * 14'd205;
            conv_next.tens[i]  = {1'b0, prod_tens[i][13:11]};
            conv_next.units[i] = vals[i][3:0] - 4'(conv_next.tens[i] * 4'd10);
        end
        // Quotients by 10, 100 and 1000; exact for all years below 10000.
        p10   = 30'(in_capt.snap.year) * 30'd52429;
        p100  = 27'(in_capt.snap.year) * 27'd5243;
        p1000 = 28'(in_capt.snap.year) * 28'd8389;
        conv_next.year_low = in_capt.snap.year;
        conv_next.q10      = p10[28:19];
        conv_next.q100     = p100[25:19];
        conv_next.q1000    = p1000[26:23];
        conv_next.mask     = in_capt.mask;
        conv_next.full     = in_capt.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            conv_reg <= conv_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_conv  = conv_reg;

endmodule

### sv/ldw_serializer.sv
module ldw_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ldw_pkg::conv_t        in_conv,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_cmd,
    output logic                  out_last,
    output ldw_pkg::ser_status_t  status
);

    logic [5:0]           mask_reg;
    logic                 full_reg;
    ldw_pkg::pos_t        pos_reg;
    logic [13:0][3:0]     digits_reg;
    logic [13:0][3:0]     digits_next;
    logic                 out_valid_reg;
    logic [7:0]           byte_reg;
    logic                 cmd_reg;
    logic                 last_reg;

    ldw_pkg::field_idx_t  cur_f;
    logic                 emit;
    logic                 field_done;
    logic [5:0]           rest_mask;
    logic                 load;
    logic [3:0]           dig_idx;
    logic [7:0]           cur_byte;
    logic                 cur_cmd;

    assign cur_f      = ldw_pkg::lowest_field(mask_reg);
    assign emit       = (mask_reg != 6'd0) && (!out_valid_reg || out_ready);
    assign field_done = pos_reg == ldw_pkg::field_len(cur_f);
    assign rest_mask  = mask_reg & ~(6'd1 << cur_f);
    assign load       = in_valid && in_ready;
    assign in_ready   = (mask_reg == 6'd0) || (emit && field_done && rest_mask == 6'd0);
    assign dig_idx    = 4'(ldw_pkg::digit_base(cur_f) + 4'(pos_reg) - 4'd1);

    always_comb
    begin
        if (pos_reg == 3'd0)
        begin
            cur_byte = ldw_pkg::prefix_byte(full_reg, cur_f);
            cur_cmd  = ldw_pkg::prefix_is_cmd(full_reg, cur_f);
        end
        else
        begin
            cur_byte = ldw_pkg::ASCII_ZERO + 8'(digits_reg[dig_idx]);
            cur_cmd  = 1'b0;
        end
    end

    // The remaining year digits come from the registered quotients; each is
    // known to lie in 0..9, so the low four bits of the difference suffice.
    always_comb
    begin
        digits_next[0]  = in_conv.tens[0];
        digits_next[1]  = in_conv.units[0];
        digits_next[2]  = in_conv.tens[1];
        digits_next[3]  = in_conv.units[1];
        digits_next[4]  = in_conv.q1000;
        digits_next[5]  = in_conv.q100[3:0] - 4'(in_conv.q1000 * 4'd10);
        digits_next[6]  = in_conv.q10[3:0] - 4'(in_conv.q100[3:0] * 4'd10);
        digits_next[7]  = in_conv.year_low[3:0] - 4'(in_conv.q10[3:0] * 4'd10);
        digits_next[8]  = in_conv.tens[2];
        digits_next[9]  = in_conv.units[2];
        digits_next[10] = in_conv.tens[3];
        digits_next[11] = in_conv.units[3];
        digits_next[12] = in_conv.tens[4];
        digits_next[13] = in_conv.units[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 6'd0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg <= in_conv.mask;
                pos_reg  <= 3'd0;
            end
            else if (emit)
            begin
                if (field_done)
                begin
                    mask_reg <= rest_mask;
                    pos_reg  <= 3'd0;
                end
                else
                begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            full_reg   <= in_conv.full;
            digits_reg <= digits_next;
        end
        if (emit)
        begin
            byte_reg <= cur_byte;
            cmd_reg  <= cur_cmd;
            last_reg <= field_done && (rest_mask == 6'd0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign out_cmd     = cmd_reg;
    assign out_last    = last_reg;
    assign status.mask = mask_reg;
    assign status.pos  = pos_reg;

endmodule

### sv/lcd_datetime_delta_writer_core.sv
// Turns date-time snapshots into byte writes for a two-line HD44780 display.
// The first snapshot after reset writes the whole layout (home command,
// dd/mm/yyyy, line-two command, hh:mm:ss: 20 bytes); each later snapshot
// writes, for every field that changed, its cursor command and its digits,
// and a snapshot with no change writes nothing. tuser marks a command byte
// and tlast the final byte of a snapshot. The output register sends one
// byte per cycle while m_axis_tready is high; the serializer can take the
// next snapshot as it sends the last byte of the one before. The capture
// and decimal conversion registers hold one snapshot each, so input is
// taken while an earlier one is being written, until they fill. Snapshots
// go through the capture, decimal conversion and byte selection stages.
module lcd_datetime_delta_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // day[4:0], month[8:5], year[22:9], hour[27:23], minute[33:28], second[39:34]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lcd_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // is_command[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    logic                  capt_valid;
    logic                  capt_ready;
    ldw_pkg::capt_t        capt;
    logic                  conv_valid;
    logic                  conv_ready;
    ldw_pkg::conv_t        conv;
    ldw_pkg::ser_status_t  ser_status;

    ldw_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (capt_valid),
        .out_ready (capt_ready),
        .out_capt  (capt)
    );

    ldw_bcd u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (capt_valid),
        .in_ready  (capt_ready),
        .in_capt   (capt),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_conv  (conv)
    );

    ldw_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_ready  (conv_ready),
        .in_conv   (conv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_cmd   (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .status    (ser_status)
    );

    // Command bytes are either the home command or a cursor address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[7] || m_axis_tdata == ldw_pkg::CMD_HOME))
        else $error("command byte is neither home nor a cursor address");

    // Data bytes are decimal digits or separators.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        ((m_axis_tdata >= ldw_pkg::ASCII_ZERO && m_axis_tdata <= ldw_pkg::ASCII_NINE)
         || m_axis_tdata == ldw_pkg::ASCII_SLASH || m_axis_tdata == ldw_pkg::ASCII_COLON))
        else $error("data byte is not a digit or separator");

    // The position within a field never runs past the longest field.
    assert property (@(posedge clk) disable iff (!rst_n)
        ser_status.pos <= 3'd4)
        else $error("field position out of range");

    // A digit position is only reached by stepping through a pending field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ser_status.pos != 3'd0) |-> ($past(ser_status.mask) != 6'd0))
        else $error("digit position reached with no field pending");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int RAND_ITEMS   = 88;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int LIMIT_NS     = 1_000_000;

    // What comes before each field: in the full layout, then in a partial update.
    localparam logic [7:0] LAYOUT_LEAD [ldw_pkg::NUM_FIELDS] = '{
        ldw_pkg::CMD_HOME, ldw_pkg::ASCII_SLASH, ldw_pkg::ASCII_SLASH,
        ldw_pkg::CMD_CUR_HOUR, ldw_pkg::ASCII_COLON, ldw_pkg::ASCII_COLON};
    localparam logic [7:0] CURSOR_CMD [ldw_pkg::NUM_FIELDS] = '{
        ldw_pkg::CMD_CUR_DAY, ldw_pkg::CMD_CUR_MONTH, ldw_pkg::CMD_CUR_YEAR,
        ldw_pkg::CMD_CUR_HOUR, ldw_pkg::CMD_CUR_MINUTE, ldw_pkg::CMD_CUR_SECOND};
    localparam int unsigned DECIMAL_PLACE [4] = '{1, 10, 100, 1000};

    typedef struct packed {
        logic [7:0] data;
        logic       is_cmd;
        logic       last;
    } lcd_write_t;

    typedef struct {
        int unsigned day;
        int unsigned month;
        int unsigned year;
        int unsigned hour;
        int unsigned minute;
        int unsigned second;
        bit          typed;
        string       writes;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    lcd_write_t      expected_writes [$];
    lcd_write_t      next_writes [$];
    bit              layout_drawn;
    ldw_pkg::snap_t  prev_shown;
    int              mismatches;
    int              bytes_seen;
    bit              long_hold_done;

    lcd_datetime_delta_writer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Display writes caused by one snapshot; also advances the shown state.
    function automatic void predict_writes(input ldw_pkg::snap_t s);
        int unsigned cur [ldw_pkg::NUM_FIELDS];
        int unsigned old [ldw_pkg::NUM_FIELDS];
        lcd_write_t  w;
        next_writes.delete();
        cur = '{s.day, s.month, s.year, s.hour, s.minute, s.second};
        old = '{prev_shown.day, prev_shown.month, prev_shown.year,
                prev_shown.hour, prev_shown.minute, prev_shown.second};
        for (int f = 0; f < ldw_pkg::NUM_FIELDS; f++)
        begin
            if (!layout_drawn || cur[f] != old[f])
            begin
                w.data   = layout_drawn ? CURSOR_CMD[f] : LAYOUT_LEAD[f];
                w.is_cmd = layout_drawn || f == ldw_pkg::FLD_DAY || f == ldw_pkg::FLD_HOUR;
                w.last   = 1'b0;
                next_writes.push_back(w);
                for (int p = (f == ldw_pkg::FLD_YEAR) ? 3 : 1; p >= 0; p--)
                begin
                    w.data   = ldw_pkg::ASCII_ZERO + 8'((cur[f] / DECIMAL_PLACE[p]) % 10);
                    w.is_cmd = 1'b0;
                    next_writes.push_back(w);
                end
            end
        end
        if (next_writes.size() > 0)
        begin
            w      = next_writes.pop_back();
            w.last = 1'b1;
            next_writes.push_back(w);
        end
        layout_drawn = 1'b1;
        prev_shown   = s;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_snapshot(input ldw_pkg::snap_t s, input int gap, input bit typed,
                                 input string writes);
        lcd_write_t w;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {s.second, s.minute, s.hour, s.year, s.month, s.day};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_writes(s);
        if (typed)
        begin
            for (int i = 0; i < writes.len(); i++)
            begin
                w.data   = writes[i];
                w.is_cmd = (w.data < 8'h20) || w.data[7];
                w.last   = (i == writes.len() - 1);
                expected_writes.push_back(w);
            end
        end
        else
        begin
            foreach (next_writes[i])
                expected_writes.push_back(next_writes[i]);
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        lcd_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_seen = bytes_seen + 1;
            if (expected_writes.size() == 0)
            begin
                report_mismatch("write with none expected", m_axis_tdata, 0);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("lcd_byte", m_axis_tdata, want.data);
                if (m_axis_tuser !== want.is_cmd)
                    report_mismatch("is_command", m_axis_tuser, want.is_cmd);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", m_axis_tlast, want.last);
            end
        end
    end

    initial
    begin : receiver
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            // One long hold-off so that the block fills up and stalls its input.
            if (!long_hold_done && bytes_seen >= 60)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            else if (stall_left == 0 && !(bytes_seen >= 150 && bytes_seen < 300))
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t             dir_table [22];
        ldw_pkg::snap_t       snap;
        ldw_pkg::field_idx_t  pick;
        int                   kind;
        mismatches     = 0;
        bytes_seen     = 0;
        long_hold_done = 1'b0;
        layout_drawn   = 1'b0;
        prev_shown     = '0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        dir_table = '{
            '{31, 12,  9999, 23, 59, 59, 1'b1, "\00231/12/9999\30023:59:59"},
            '{31, 12,  9999, 23, 59, 59, 1'b1, ""},
            '{ 1,  1,     0,  0,  0,  0, 1'b1, "\20001\20301\2060000\30000\30300\30600"},
            '{31, 15, 16383, 31, 63, 63, 1'b1, "\20031\20315\2066383\30031\30363\30663"},
            '{ 0,  0,     0,  0,  0,  0, 1'b0, ""},
            '{ 0,  0,     0,  0,  0,  1, 1'b0, ""},
            '{ 0,  0,     0,  0,  1,  1, 1'b0, ""},
            '{ 0,  0,     0,  1,  1,  1, 1'b0, ""},
            '{ 0,  0, 10000,  1,  1,  1, 1'b1, "\2060000"},
            '{ 0,  0, 12345,  1,  1,  1, 1'b1, "\2062345"},
            '{ 0,  7, 12345,  1,  1,  1, 1'b0, ""},
            '{ 9,  7, 12345,  1,  1,  1, 1'b0, ""},
            '{ 9,  7, 12345,  1,  1,  1, 1'b1, ""},
            '{10, 10,  1000, 10, 10, 10, 1'b0, ""},
            '{16,  8,  8192, 16, 32, 32, 1'b0, ""},
            '{28,  2,  2024, 12, 30, 45, 1'b0, ""},
            '{28,  2,  2024, 12, 30, 46, 1'b0, ""},
            '{28,  2,  2024, 12, 31,  0, 1'b0, ""},
            '{ 1,  3,  2024,  0,  0,  0, 1'b0, ""},
            '{31, 12,  1999, 23, 59, 59, 1'b0, ""},
            '{ 1,  1,  2000,  0,  0,  0, 1'b0, ""},
            '{ 5,  5,     5,  5,  5,  5, 1'b0, ""}
        };
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_table[k])
        begin
            snap.day    = 5'(dir_table[k].day);
            snap.month  = 4'(dir_table[k].month);
            snap.year   = 14'(dir_table[k].year);
            snap.hour   = 5'(dir_table[k].hour);
            snap.minute = 6'(dir_table[k].minute);
            snap.second = 6'(dir_table[k].second);
            send_snapshot(snap, $urandom_range(0, 2), dir_table[k].typed,
                          dir_table[k].writes);
        end

        // Let the output run dry before the random part starts.
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_writes.size() != 0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // A clock advancing by one second, with carries up to the year.
                if (snap.second >= 59)
                begin
                    snap.second = 6'd0;
                    if (snap.minute >= 59)
                    begin
                        snap.minute = 6'd0;
                        if (snap.hour >= 23)
                        begin
                            snap.hour = 5'd0;
                            if (snap.day >= 28)
                            begin
                                snap.day = 5'd1;
                                if (snap.month >= 12)
                                begin
                                    snap.month = 4'd1;
                                    snap.year  = snap.year + 14'd1;
                                end
                                else
                                    snap.month = snap.month + 4'd1;
                            end
                            else
                                snap.day = snap.day + 5'd1;
                        end
                        else
                            snap.hour = snap.hour + 5'd1;
                    end
                    else
                        snap.minute = snap.minute + 6'd1;
                end
                else
                    snap.second = snap.second + 6'd1;
            end
            else if (kind == 7)
            begin
                pick = ldw_pkg::field_idx_t'($urandom_range(0, ldw_pkg::NUM_FIELDS - 1));
                case (pick)
                    ldw_pkg::FLD_DAY:    snap.day    = 5'($urandom_range(0, 31));
                    ldw_pkg::FLD_MONTH:  snap.month  = 4'($urandom_range(0, 15));
                    ldw_pkg::FLD_YEAR:   snap.year   = 14'($urandom_range(0, 16383));
                    ldw_pkg::FLD_HOUR:   snap.hour   = 5'($urandom_range(0, 31));
                    ldw_pkg::FLD_MINUTE: snap.minute = 6'($urandom_range(0, 63));
                    default:             snap.second = 6'($urandom_range(0, 63));
                endcase
            end
            else if (kind == 8)
            begin
                snap.day    = 5'($urandom_range(0, 31));
                snap.month  = 4'($urandom_range(0, 15));
                snap.year   = 14'($urandom_range(0, 16383));
                snap.hour   = 5'($urandom_range(0, 31));
                snap.minute = 6'($urandom_range(0, 63));
                snap.second = 6'($urandom_range(0, 63));
            end
            else if (kind == 9)
            begin
                snap.day    = 5'($urandom_range(1, 31));
                snap.month  = 4'($urandom_range(1, 12));
                snap.year   = 14'($urandom_range(0, 9999));
                snap.hour   = 5'($urandom_range(0, 23));
                snap.minute = 6'($urandom_range(0, 59));
                snap.second = 6'($urandom_range(0, 59));
            end
            // kind 6 repeats the previous snapshot, which causes no writes.

            if (i == RAND_ITEMS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (expected_writes.size() != 0);
            end
            send_snapshot(snap, (i >= 30 && i < 55) ? 0 : pick_gap(), 1'b0, "");
        end
        s_axis_tvalid <= 1'b0;

        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** lcd_datetime_delta_writer_core: PASSED **");
        else
            $display("** lcd_datetime_delta_writer_core: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("** lcd_datetime_delta_writer_core: FAILED **");
        $finish;
    end

endmodule
